@@ hw/rtl/fqsd_pkg.sv @@
// ----------------------------------------------------------------------------
// fqsd_pkg
// Shared constants, codes and types of the searchable bounded queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fqsd_pkg;

  localparam int DEPTH = 16;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DW    = 32;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic [1:0] OP_INS  = 2'd0;
  localparam logic [1:0] OP_DEL  = 2'd1;
  localparam logic [1:0] OP_FIND = 2'd2;
  localparam logic [1:0] OP_NOP  = 2'd3;

  typedef struct packed {
    logic [1:0]    kind;
    logic [DW-1:0] value;
  } op_t;

endpackage

`default_nettype wire

@@ hw/rtl/fqsd_ram.sv @@
// ----------------------------------------------------------------------------
// fqsd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fqsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/fqsd_front.sv @@
// ----------------------------------------------------------------------------
// fqsd_front
// Accepts command words, decodes them into operations and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fqsd_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_stall,
  input  wire logic [1:0]         command,
  input  wire logic signed [31:0] value,
  output logic                    op_valid,
  input  wire logic               op_pop,
  output fqsd_pkg::op_t           op
);

  fqsd_pkg::op_t slot [2];
  fqsd_pkg::op_t dec;
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  logic          push;
  logic          pop;

  always_comb begin
    case (command)
      fqsd_pkg::CMD_INSERT: dec.kind = fqsd_pkg::OP_INS;
      fqsd_pkg::CMD_DELETE: dec.kind = fqsd_pkg::OP_DEL;
      fqsd_pkg::CMD_FIND:   dec.kind = fqsd_pkg::OP_FIND;
      default:              dec.kind = fqsd_pkg::OP_NOP;
    endcase
    dec.value = $unsigned(value);
  end

  assign cmd_stall = (fill == 2'd2);
  assign push      = cmd_valid && !cmd_stall;
  assign op_valid  = (fill != 2'd0);
  assign pop       = op_valid && op_pop;
  assign op        = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/fqsd_back.sv @@
// ----------------------------------------------------------------------------
// fqsd_back
// Executes queue operations: append, front-to-back search with one compare
// per cycle, and gap closing after a delete; drives the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fqsd_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      op_valid,
  output logic                           op_pop,
  input  wire fqsd_pkg::op_t             op,
  output logic                           res_valid,
  input  wire logic                      res_stall,
  output logic [1:0]                     status,
  output logic [fqsd_pkg::CW-1:0]        position,
  output logic [fqsd_pkg::CW-1:0]        entry_count
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SRCH  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_RES   = 2'd3;

  localparam logic [fqsd_pkg::CW-1:0] FULL_COUNT = fqsd_pkg::CW'(fqsd_pkg::DEPTH);
  localparam logic [fqsd_pkg::CW-1:0] ONE        = fqsd_pkg::CW'(1);
  localparam logic [fqsd_pkg::CW-1:0] TWO        = fqsd_pkg::CW'(2);

  logic [1:0]                  state;
  logic [1:0]                  state_next;
  logic [fqsd_pkg::CW-1:0]     cnt;
  logic [fqsd_pkg::CW-1:0]     cnt_next;
  logic [fqsd_pkg::AW-1:0]     idx;
  logic [fqsd_pkg::AW-1:0]     idx_next;
  logic [fqsd_pkg::DW-1:0]     key;
  logic [fqsd_pkg::DW-1:0]     key_next;
  logic                        is_del;
  logic                        is_del_next;
  logic [1:0]                  res_st;
  logic [1:0]                  res_st_next;
  logic [fqsd_pkg::CW-1:0]     res_pos;
  logic [fqsd_pkg::CW-1:0]     res_pos_next;

  logic                        we;
  logic [fqsd_pkg::AW-1:0]     waddr;
  logic [fqsd_pkg::DW-1:0]     wdata;
  logic [fqsd_pkg::AW-1:0]     raddr;
  logic [fqsd_pkg::DW-1:0]     rdata;

  logic [fqsd_pkg::CW-1:0]     idx_p1;
  logic [fqsd_pkg::CW-1:0]     idx_p2;
  logic                        out_free;

  assign idx_p1   = fqsd_pkg::CW'(idx) + ONE;
  assign idx_p2   = fqsd_pkg::CW'(idx) + TWO;
  assign out_free = !res_valid || !res_stall;

  fqsd_ram #(
    .WIDTH (fqsd_pkg::DW),
    .DEPTH (fqsd_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    idx_next     = idx;
    key_next     = key;
    is_del_next  = is_del;
    res_st_next  = res_st;
    res_pos_next = res_pos;
    op_pop       = 1'b0;
    we           = 1'b0;
    waddr        = idx;
    wdata        = rdata;
    raddr        = '0;
    case (state)
      S_IDLE: begin
        op_pop = op_valid;
        if (op_valid) begin
          res_st_next  = fqsd_pkg::ST_OK;
          res_pos_next = '0;
          idx_next     = '0;
          key_next     = op.value;
          is_del_next  = (op.kind == fqsd_pkg::OP_DEL);
          state_next   = S_RES;
          case (op.kind)
            fqsd_pkg::OP_INS: begin
              if (cnt == FULL_COUNT) begin
                res_st_next = fqsd_pkg::ST_FULL;
              end else begin
                we       = 1'b1;
                waddr    = cnt[fqsd_pkg::AW-1:0];
                wdata    = op.value;
                cnt_next = cnt + ONE;
              end
            end
            fqsd_pkg::OP_DEL, fqsd_pkg::OP_FIND: begin
              if (cnt == '0) begin
                res_st_next = fqsd_pkg::ST_NOT_FOUND;
              end else begin
                state_next = S_SRCH;
              end
            end
            default: begin
              res_st_next = fqsd_pkg::ST_OK;
            end
          endcase
        end
      end
      S_SRCH: begin
        raddr = idx_p1[fqsd_pkg::AW-1:0];
        if (rdata == key) begin
          res_pos_next = idx_p1;
          if (!is_del) begin
            state_next = S_RES;
          end else if (idx_p1 == cnt) begin
            cnt_next   = cnt - ONE;
            state_next = S_RES;
          end else begin
            state_next = S_SHIFT;
          end
        end else if (idx_p1 == cnt) begin
          res_st_next = fqsd_pkg::ST_NOT_FOUND;
          state_next  = S_RES;
        end else begin
          idx_next = idx_p1[fqsd_pkg::AW-1:0];
        end
      end
      S_SHIFT: begin
        raddr = idx_p2[fqsd_pkg::AW-1:0];
        we    = 1'b1;
        waddr = idx;
        wdata = rdata;
        if (idx_p2 == cnt) begin
          cnt_next   = cnt - ONE;
          state_next = S_RES;
        end else begin
          idx_next = idx_p1[fqsd_pkg::AW-1:0];
        end
      end
      S_RES: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (state == S_RES && out_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    key     <= key_next;
    is_del  <= is_del_next;
    res_st  <= res_st_next;
    res_pos <= res_pos_next;
    if (state == S_RES && out_free) begin
      status      <= res_st;
      position    <= res_pos;
      entry_count <= cnt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/fifo_queue_search_delete.sv @@
// ----------------------------------------------------------------------------
// fifo_queue_search_delete
// Bounded ordered queue of 32-bit values with append, find-and-delete and
// find-position commands; one result word per command word.
// ----------------------------------------------------------------------------
//  channel  signals                          direction
//  cmd      cmd_valid/cmd_stall, command, value        in
//  res      res_valid/res_stall, status, position,     out
//           entry_count
//
// Insert and unused commands go straight from idle to the result state in
// the back end. A search compares the entries front to back (single
// comparator on the RAM read port); a delete then moves each entry behind
// the match down one place. Reset clears the count, the front queue and
// res_valid; entry storage needs no clearing.
// The front holds two decoded words; while res stalls, cmd flows until both fill.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fifo_queue_search_delete (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cmd_valid,
  output logic                           cmd_stall,
  input  wire logic [1:0]                command,
  input  wire logic signed [31:0]        value,
  output logic                           res_valid,
  input  wire logic                      res_stall,
  output logic [1:0]                     status,
  output logic [fqsd_pkg::CW-1:0]        position,
  output logic [fqsd_pkg::CW-1:0]        entry_count
);

  fqsd_pkg::op_t op;
  logic          op_valid;
  logic          op_pop;

  fqsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .command   (command),
    .value     (value),
    .op_valid  (op_valid),
    .op_pop    (op_pop),
    .op        (op)
  );

  fqsd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .op_valid    (op_valid),
    .op_pop      (op_pop),
    .op          (op),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .status      (status),
    .position    (position),
    .entry_count (entry_count)
  );

endmodule

`default_nettype wire
